[hdl/capacitive_water_presence_detector_assert.svh]
// Assertion macros for the capacitive water presence detector.
// Users provide clk and rst in scope; no other dependencies.
`ifndef CAPACITIVE_WATER_PRESENCE_DETECTOR_ASSERT_SVH
`define CAPACITIVE_WATER_PRESENCE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CWPD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwpd check failed");
// next-cycle implication
`define CWPD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwpd check failed");
`else
`define CWPD_ASSERT_IMP(name, ante, cons)
`define CWPD_ASSERT_NXT(name, ante, cons)
`endif
`endif

[hdl/cwpd_pkg.sv]
// Shared constants and types for the capacitive water presence detector.
// No dependencies.
package cwpd_pkg;

  // window depths and wet timeout
  localparam int SHORT_DEPTH  = 8;
  localparam int SLOW_DEPTH   = 64;
  localparam int MEAN_DEPTH   = 200;
  localparam int SQUARE_DEPTH = 30;
  localparam int RANGE_DEPTH  = 128;
  localparam logic [31:0] WET_TIMEOUT_MS = 32'd18000000;

  // ring positions, fills and exact totals
  localparam int SHORT_POS_W  = (SHORT_DEPTH > 1) ? $clog2(SHORT_DEPTH) : 1;
  localparam int SLOW_POS_W   = (SLOW_DEPTH > 1) ? $clog2(SLOW_DEPTH) : 1;
  localparam int MEAN_POS_W   = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int SQUARE_POS_W = (SQUARE_DEPTH > 1) ? $clog2(SQUARE_DEPTH) : 1;
  localparam int RANGE_POS_W  = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
  localparam int SHORT_FILL_W  = $clog2(SHORT_DEPTH + 1);
  localparam int SLOW_FILL_W   = $clog2(SLOW_DEPTH + 1);
  localparam int MEAN_FILL_W   = $clog2(MEAN_DEPTH + 1);
  localparam int SQUARE_FILL_W = $clog2(SQUARE_DEPTH + 1);
  localparam int RANGE_FILL_W  = $clog2(RANGE_DEPTH + 1);
  localparam int SHORT_TOT_W  = 16 + $clog2(SHORT_DEPTH);
  localparam int SLOW_TOT_W   = 16 + $clog2(SLOW_DEPTH);
  localparam int MEAN_TOT_W   = 16 + $clog2(MEAN_DEPTH);
  localparam int SQUARE_TOT_W = 32 + $clog2(SQUARE_DEPTH);
  localparam int ACC_W        = SQUARE_TOT_W;

  // one shared RAM, one region per window
  localparam int SHORT_BASE  = 0;
  localparam int SLOW_BASE   = SHORT_BASE + SHORT_DEPTH;
  localparam int MEAN_BASE   = SLOW_BASE + SLOW_DEPTH;
  localparam int SQUARE_BASE = MEAN_BASE + MEAN_DEPTH;
  localparam int RANGE_BASE  = SQUARE_BASE + SQUARE_DEPTH;
  localparam int RAM_DEPTH   = RANGE_BASE + RANGE_DEPTH;
  localparam int RAM_W       = 32;
  localparam int ADDR_W      = $clog2(RAM_DEPTH);

  // divider sizes: covers window totals and the EMA numerator
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 17;

  // modes
  localparam logic [1:0] MODE_DYNAMIC  = 2'd0;
  localparam logic [1:0] MODE_DISCRETE = 2'd1;
  localparam logic [1:0] MODE_ENVELOPE = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RISE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALL       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEAVE      = 3'd7;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/cwpd_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
module cwpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/cwpd_div.sv]
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Depends on cwpd_pkg.
module cwpd_div import cwpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 flush,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_stat_t            stat,
  output logic [DIV_NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;

  // one restoring step
  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign take  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(DIV_NUM_W);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= take ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

[hdl/capacitive_water_presence_detector.sv]
// Capacitive water presence detector, top level with window sequencer.
// Depends on cwpd_pkg, cwpd_ram, cwpd_div and the assertion macro header.
//
// One result item per input item. Dynamic and discrete mode each run two
// window updates per item: each reads the shared RAM, writes back and runs
// a 41-step shift-subtract division for the mean. Envelope mode does one
// RAM read per stored sample for max/min, then one division for the
// dry-level EMA; while wet or on the first seed the division is skipped.
// Input is taken only while the sequencer is idle; a finished result waits
// in the output register without blocking input.
// A configuration write resets all detector state.
`include "capacitive_water_presence_detector_assert.svh"
module capacitive_water_presence_detector import cwpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          sample,
  input  logic [31:0]          now_ms,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 water_present,
  output logic                 state_changed,
  output logic                 watchdog_fired,
  output logic [15:0]          shown_primary,
  output logic [15:0]          shown_secondary,
  output logic [15:0]          shown_threshold
);
  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD       = 4'd1;
  localparam logic [3:0] S_PUSH     = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_SQ       = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_SCAN_END = 4'd6;
  localparam logic [3:0] S_RANGE    = 4'd7;
  localparam logic [3:0] S_EMA      = 4'd8;
  localparam logic [3:0] S_DECIDE   = 4'd9;

  // window being updated, or the EMA division
  localparam logic [2:0] RING_SHORT  = 3'd0;
  localparam logic [2:0] RING_SLOW   = 3'd1;
  localparam logic [2:0] RING_MEAN   = 3'd2;
  localparam logic [2:0] RING_SQUARE = 3'd3;
  localparam logic [2:0] RING_EMA    = 3'd4;

  // config registers
  logic [1:0]         algo_mode;
  logic signed [16:0] offset;
  logic [31:0]        var_limit;
  logic [7:0]         env_span;
  logic [15:0]        rise_win;
  logic [15:0]        fall_win;
  logic signed [16:0] enter_margin;
  logic signed [16:0] leave_margin;

  // detector state
  logic [3:0]               state;
  logic [2:0]               ring_sel;
  logic                     wet_flag;
  logic [31:0]              wet_since;
  logic [SHORT_TOT_W-1:0]   short_total;
  logic [SHORT_POS_W-1:0]   short_pos;
  logic [SHORT_FILL_W-1:0]  short_fill;
  logic [SLOW_TOT_W-1:0]    slow_total;
  logic [SLOW_POS_W-1:0]    slow_pos;
  logic [SLOW_FILL_W-1:0]   slow_fill;
  logic [MEAN_TOT_W-1:0]    mean_total;
  logic [MEAN_POS_W-1:0]    mean_pos;
  logic [MEAN_FILL_W-1:0]   mean_fill;
  logic [SQUARE_TOT_W-1:0]  square_total;
  logic [SQUARE_POS_W-1:0]  square_pos;
  logic [SQUARE_FILL_W-1:0] square_fill;
  logic [RANGE_POS_W-1:0]   range_pos;
  logic [RANGE_FILL_W-1:0]  range_fill;
  logic [23:0]              dry_level;
  logic                     dry_valid;

  // per-item working registers
  logic [15:0]             sample_r;
  logic [31:0]             now_r;
  logic [31:0]             push_val;
  logic [15:0]             filt;
  logic [15:0]             base;
  logic [15:0]             mean_val;
  logic [31:0]             var_val;
  logic [15:0]             hi;
  logic [15:0]             lo;
  logic [RANGE_FILL_W-1:0] scan_idx;
  logic                    scan_vld;
  logic                    scan_first;
  logic [39:0]             ema_prod;
  logic [15:0]             ema_w;

  logic cfg_hit;
  logic in_acc;
  logic out_free;
  logic out_load;

  assign cfg_hit  = cfg_write;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DECIDE) && out_free;

  // clamp of base +/- offset
  function automatic logic [15:0] thr_of(input logic [15:0] b, input logic wet,
                                         input logic signed [16:0] off);
    logic signed [18:0] t;
    t = $signed({3'b000, b}) + (wet ? -19'(off) : 19'(off));
    if (t < 0) begin
      return 16'd0;
    end else if (t > 19'sd65535) begin
      return 16'hFFFF;
    end
    return t[15:0];
  endfunction

  // ------------------------------------------------------------------
  // shared RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  cwpd_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------------
  // selected ring view
  logic [ACC_W-1:0]     sel_total;
  logic [DIV_DEN_W-1:0] sel_fill;
  logic                 sel_full;
  logic [ADDR_W-1:0]    sel_addr;

  always_comb begin
    unique case (ring_sel)
      RING_SHORT: begin
        sel_total = ACC_W'(short_total);
        sel_fill  = DIV_DEN_W'(short_fill);
        sel_full  = short_fill == SHORT_FILL_W'(SHORT_DEPTH);
        sel_addr  = ADDR_W'(SHORT_BASE) + ADDR_W'(short_pos);
      end
      RING_SLOW: begin
        sel_total = ACC_W'(slow_total);
        sel_fill  = DIV_DEN_W'(slow_fill);
        sel_full  = slow_fill == SLOW_FILL_W'(SLOW_DEPTH);
        sel_addr  = ADDR_W'(SLOW_BASE) + ADDR_W'(slow_pos);
      end
      RING_MEAN: begin
        sel_total = ACC_W'(mean_total);
        sel_fill  = DIV_DEN_W'(mean_fill);
        sel_full  = mean_fill == MEAN_FILL_W'(MEAN_DEPTH);
        sel_addr  = ADDR_W'(MEAN_BASE) + ADDR_W'(mean_pos);
      end
      RING_SQUARE: begin
        sel_total = ACC_W'(square_total);
        sel_fill  = DIV_DEN_W'(square_fill);
        sel_full  = square_fill == SQUARE_FILL_W'(SQUARE_DEPTH);
        sel_addr  = ADDR_W'(SQUARE_BASE) + ADDR_W'(square_pos);
      end
      default: begin
        sel_total = '0;
        sel_fill  = '0;
        sel_full  = 1'b0;
        sel_addr  = '0;
      end
    endcase
  end

  // total after dropping the oldest entry and adding the new one
  logic [ACC_W-1:0] new_total;
  assign new_total = sel_total - (sel_full ? ACC_W'(ram_rdata) : ACC_W'(0))
                   + ACC_W'(push_val);

  // ------------------------------------------------------------------
  // envelope window write position
  logic [15:0]             span16;
  logic [RANGE_FILL_W-1:0] span_c;
  logic [RANGE_FILL_W-1:0] pos_eff;
  logic [RANGE_FILL_W-1:0] pos_inc;

  assign span16  = (env_span == 8'd0) ? 16'd1 :
                   (16'(env_span) > 16'(RANGE_DEPTH)) ? 16'(RANGE_DEPTH) : 16'(env_span);
  assign span_c  = RANGE_FILL_W'(span16);
  assign pos_eff = (RANGE_FILL_W'(range_pos) >= span_c) ? '0 : RANGE_FILL_W'(range_pos);
  assign pos_inc = pos_eff + 1'b1;

  // range and dry-level helpers
  logic [15:0]        rng;
  logic [23:0]        rq;
  logic [15:0]        wsel;
  logic [15:0]        wm;
  logic [39:0]        ema_mul;
  logic [DIV_NUM_W-1:0] ema_num;
  logic [DIV_DEN_W-1:0] ema_den;

  assign rng     = hi - lo;
  assign rq      = {rng, 8'd0};
  assign wsel    = (rq > dry_level) ? rise_win : fall_win;
  assign wm      = (wsel == 16'd0) ? 16'd1 : wsel;
  assign ema_mul = (wm - 16'd1) * dry_level;
  assign ema_den = DIV_DEN_W'(ema_w) + 1'b1;
  assign ema_num = DIV_NUM_W'({rq, 1'b0}) + DIV_NUM_W'(ema_prod)
                 + DIV_NUM_W'(ema_den >> 1);

  // squared deviation from the long mean
  logic [15:0] dev;
  logic [31:0] dev_sq;
  assign dev    = (sample_r >= mean_val) ? sample_r - mean_val : mean_val - sample_r;
  assign dev_sq = dev * dev;

  // ------------------------------------------------------------------
  // divider
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_quo;

  assign div_start = (state == S_PUSH) || (state == S_EMA);
  assign div_num   = (state == S_EMA) ? ema_num : DIV_NUM_W'(new_total);
  assign div_den   = (state == S_EMA) ? ema_den :
                     (sel_full ? sel_fill : sel_fill + 1'b1);

  cwpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .flush (cfg_hit),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // ------------------------------------------------------------------
  // RAM port control
  logic env_acc;
  assign env_acc   = in_acc && (algo_mode == MODE_ENVELOPE);
  assign ram_we    = (state == S_PUSH) || env_acc;
  assign ram_waddr = (state == S_PUSH) ? sel_addr
                                       : ADDR_W'(RANGE_BASE) + ADDR_W'(pos_eff);
  assign ram_wdata = (state == S_PUSH) ? push_val : RAM_W'(sample);
  assign ram_raddr = (state == S_SCAN)
                     ? ADDR_W'(RANGE_BASE) + ADDR_W'(scan_idx[RANGE_POS_W-1:0])
                     : sel_addr;

  // ------------------------------------------------------------------
  // decision for the item
  logic        dec_wet;
  logic [31:0] dec_since;
  logic        dec_fired;
  logic [15:0] dec_prim;
  logic [15:0] dec_sec;
  logic [15:0] dyn_thr;
  logic        dyn_next;
  logic signed [26:0] rq_s;
  logic signed [26:0] dq_s;
  logic signed [26:0] enter_lim;
  logic signed [26:0] leave_lim;

  assign rq_s      = $signed({3'b000, rq});
  assign dq_s      = dry_valid ? $signed({3'b000, dry_level}) : 27'sd0;
  assign enter_lim = dq_s + $signed({{2{enter_margin[16]}}, enter_margin, 8'd0});
  assign leave_lim = dq_s + $signed({{2{leave_margin[16]}}, leave_margin, 8'd0});

  always_comb begin
    dec_wet   = wet_flag;
    dec_since = wet_since;
    dec_fired = 1'b0;
    dyn_thr   = '0;
    dyn_next  = 1'b0;
    if (algo_mode == MODE_DISCRETE) begin
      dec_wet  = var_val > var_limit;
      dec_prim = (var_val > 32'd65535) ? 16'hFFFF : var_val[15:0];
      dec_sec  = mean_val;
    end else if (algo_mode == MODE_ENVELOPE) begin
      dec_wet  = wet_flag ? !(rq_s < leave_lim) : (rq_s > enter_lim);
      dec_prim = hi;
      dec_sec  = lo;
    end else begin
      dec_prim = filt;
      dec_sec  = base;
      // watchdog
      if (wet_flag) begin
        if (wet_since == 32'd0) begin
          dec_since = now_r;
        end
        if ((now_r - dec_since) >= WET_TIMEOUT_MS) begin
          dec_wet   = 1'b0;
          dec_since = '0;
          dec_fired = 1'b1;
        end
      end else begin
        dec_since = '0;
      end
      // Schmitt decision, mirrored for a negative offset
      if (!dec_fired) begin
        dyn_thr = thr_of(base, dec_wet, offset);
        if (!dec_wet) begin
          dyn_next = !offset[16] ? (filt > dyn_thr) : (filt < dyn_thr);
        end else begin
          dyn_next = !offset[16] ? !(filt < dyn_thr) : !(filt > dyn_thr);
        end
        if (dyn_next != dec_wet) begin
          dec_wet   = dyn_next;
          dec_since = dyn_next ? now_r : 32'd0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      algo_mode    <= MODE_DYNAMIC;
      offset       <= '0;
      var_limit    <= '0;
      env_span     <= 8'd30;
      rise_win     <= 16'd50;
      fall_win     <= 16'd10;
      enter_margin <= '0;
      leave_margin <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:      algo_mode    <= cfg_data[1:0];
        REG_OFFSET:    offset       <= cfg_data[16:0];
        REG_VAR_LIMIT: var_limit    <= cfg_data;
        REG_SPAN:      env_span     <= cfg_data[7:0];
        REG_RISE:      rise_win     <= cfg_data[15:0];
        REG_FALL:      fall_win     <= cfg_data[15:0];
        REG_ENTER:     enter_margin <= cfg_data[16:0];
        REG_LEAVE:     leave_margin <= cfg_data[16:0];
        default:       ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state        <= S_IDLE;
      ring_sel     <= RING_SHORT;
      wet_flag     <= 1'b0;
      wet_since    <= '0;
      short_total  <= '0;
      short_pos    <= '0;
      short_fill   <= '0;
      slow_total   <= '0;
      slow_pos     <= '0;
      slow_fill    <= '0;
      mean_total   <= '0;
      mean_pos     <= '0;
      mean_fill    <= '0;
      square_total <= '0;
      square_pos   <= '0;
      square_fill  <= '0;
      range_pos    <= '0;
      range_fill   <= '0;
      dry_level    <= '0;
      dry_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_r <= sample;
            now_r    <= now_ms;
            if (algo_mode == MODE_ENVELOPE) begin
              range_pos  <= (pos_inc == span_c) ? '0 : pos_inc[RANGE_POS_W-1:0];
              if (range_fill < span_c) begin
                range_fill <= range_fill + 1'b1;
              end
              scan_idx   <= '0;
              scan_vld   <= 1'b0;
              scan_first <= 1'b1;
              state      <= S_SCAN;
            end else begin
              ring_sel <= (algo_mode == MODE_DISCRETE) ? RING_MEAN : RING_SHORT;
              push_val <= 32'(sample);
              state    <= S_RD;
            end
          end
        end
        S_RD: state <= S_PUSH;
        S_PUSH: begin
          // write back total, position and fill of the window
          unique case (ring_sel)
            RING_SHORT: begin
              short_total <= SHORT_TOT_W'(new_total);
              short_pos   <= (short_pos == SHORT_POS_W'(SHORT_DEPTH - 1)) ? '0
                             : short_pos + 1'b1;
              if (!sel_full) short_fill <= short_fill + 1'b1;
            end
            RING_SLOW: begin
              slow_total <= SLOW_TOT_W'(new_total);
              slow_pos   <= (slow_pos == SLOW_POS_W'(SLOW_DEPTH - 1)) ? '0
                            : slow_pos + 1'b1;
              if (!sel_full) slow_fill <= slow_fill + 1'b1;
            end
            RING_MEAN: begin
              mean_total <= MEAN_TOT_W'(new_total);
              mean_pos   <= (mean_pos == MEAN_POS_W'(MEAN_DEPTH - 1)) ? '0
                            : mean_pos + 1'b1;
              if (!sel_full) mean_fill <= mean_fill + 1'b1;
            end
            RING_SQUARE: begin
              square_total <= SQUARE_TOT_W'(new_total);
              square_pos   <= (square_pos == SQUARE_POS_W'(SQUARE_DEPTH - 1)) ? '0
                              : square_pos + 1'b1;
              if (!sel_full) square_fill <= square_fill + 1'b1;
            end
            default: ;
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            unique case (ring_sel)
              RING_SHORT: begin
                filt     <= div_quo[15:0];
                push_val <= 32'(div_quo[15:0]);
                ring_sel <= RING_SLOW;
                state    <= S_RD;
              end
              RING_SLOW: begin
                base  <= div_quo[15:0];
                state <= S_DECIDE;
              end
              RING_MEAN: begin
                mean_val <= div_quo[15:0];
                state    <= S_SQ;
              end
              RING_SQUARE: begin
                var_val <= div_quo[31:0];
                state   <= S_DECIDE;
              end
              default: begin
                dry_level <= div_quo[23:0];
                state     <= S_DECIDE;
              end
            endcase
          end
        end
        S_SQ: begin
          push_val <= dev_sq;
          ring_sel <= RING_SQUARE;
          state    <= S_RD;
        end
        S_SCAN, S_SCAN_END: begin
          // fold the sample read in the previous cycle
          if (scan_vld) begin
            if (scan_first) begin
              hi         <= ram_rdata[15:0];
              lo         <= ram_rdata[15:0];
              scan_first <= 1'b0;
            end else begin
              if (ram_rdata[15:0] > hi) hi <= ram_rdata[15:0];
              if (ram_rdata[15:0] < lo) lo <= ram_rdata[15:0];
            end
          end
          if (state == S_SCAN) begin
            scan_vld <= 1'b1;
            scan_idx <= scan_idx + 1'b1;
            if (scan_idx == range_fill - 1'b1) state <= S_SCAN_END;
          end else begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          // dry level moves only while dry
          if (wet_flag) begin
            state <= S_DECIDE;
          end else if (!dry_valid) begin
            dry_level <= rq;
            dry_valid <= 1'b1;
            state     <= S_DECIDE;
          end else begin
            ema_prod <= ema_mul;
            ema_w    <= wm;
            state    <= S_EMA;
          end
        end
        S_EMA: begin
          ring_sel <= RING_EMA;
          state    <= S_DIV;
        end
        S_DECIDE: begin
          if (out_free) begin
            wet_flag  <= dec_wet;
            wet_since <= dec_since;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      water_present   <= dec_wet;
      state_changed   <= dec_wet != wet_flag;
      watchdog_fired  <= dec_fired;
      shown_primary   <= dec_prim;
      shown_secondary <= dec_sec;
      shown_threshold <= thr_of(dec_sec, dec_wet, offset);
    end
  end

  // ------------------------------------------------------------------
  // checks
  `CWPD_ASSERT_NXT(a_busy_after_accept, in_acc && !cfg_write, in_stall)
  `CWPD_ASSERT_IMP(a_div_free_on_start, div_start, !div_stat.busy)
  `CWPD_ASSERT_IMP(a_push_same_entry, state == S_PUSH, ram_waddr == $past(ram_raddr))
  `CWPD_ASSERT_IMP(a_dry_clear_by_cfg, $fell(dry_valid), $past(cfg_write || rst))
  `CWPD_ASSERT_IMP(a_fill_bounds, 1'b1,
                   (short_fill <= SHORT_FILL_W'(SHORT_DEPTH)) &&
                   (mean_fill <= MEAN_FILL_W'(MEAN_DEPTH)) &&
                   (range_fill <= RANGE_FILL_W'(RANGE_DEPTH)))
endmodule

[bench/tb_capacitive_water_presence_detector.sv]
// Self-checking bench for the capacitive water presence detector: a bit-true
// predictor of all three modes, a queued driver and a result monitor.
// Depends on cwpd_pkg and the detector RTL.
module tb_capacitive_water_presence_detector;
  import cwpd_pkg::*;

  typedef struct {
    logic [15:0] smp;
    logic [31:0] stamp;
  } stim_t;

  typedef struct {
    logic        wet;
    logic        changed;
    logic        fired;
    logic [15:0] prim;
    logic [15:0] sec;
    logic [15:0] thr;
  } verdict_t;

  localparam int unsigned WIN_DEPTH [4] = '{SHORT_DEPTH, SLOW_DEPTH, MEAN_DEPTH, SQUARE_DEPTH};
  localparam int WIN_SHORT  = 0;
  localparam int WIN_SLOW   = 1;
  localparam int WIN_MEAN   = 2;
  localparam int WIN_SQUARE = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sample = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        water_present, state_changed, watchdog_fired;
  logic [15:0] shown_primary, shown_secondary, shown_threshold;

  capacitive_water_presence_detector i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .sample, .now_ms,
    .out_valid, .out_stall, .water_present, .state_changed, .watchdog_fired,
    .shown_primary, .shown_secondary, .shown_threshold
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench bookkeeping
  stim_t    pending_items[$];
  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     hold_rx = 1'b0;

  // predictor configuration
  logic [1:0]  p_mode;
  int          p_offset;
  int unsigned p_var_limit, p_span, p_rise, p_fall;
  int          p_enter, p_leave;

  // predictor state
  logic            p_wet;
  logic [31:0]     p_wet_since;
  longint unsigned win_mem [0:3][0:255];
  int unsigned     win_pos [4];
  int unsigned     win_fill [4];
  longint unsigned win_sum [4];
  int unsigned     rng_mem [0:RANGE_DEPTH-1];
  int unsigned     rng_pos, rng_fill;
  longint          dry_q8;
  logic            dry_seeded;

  // stimulus shaping
  int          lvl = 30000;
  int          noise_amp = 50;
  logic [31:0] clock_ms = 32'd1;

  function automatic void clear_predictor();
    p_wet = 1'b0;
    p_wet_since = '0;
    for (int i = 0; i < 4; i++) begin
      win_pos[i] = 0;
      win_fill[i] = 0;
      win_sum[i] = 0;
    end
    rng_pos = 0;
    rng_fill = 0;
    dry_q8 = 0;
    dry_seeded = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_MODE:      p_mode = val[1:0];
      REG_OFFSET:    p_offset = int'($signed(val[16:0]));
      REG_VAR_LIMIT: p_var_limit = val;
      REG_SPAN:      p_span = val[7:0];
      REG_RISE:      p_rise = val[15:0];
      REG_FALL:      p_fall = val[15:0];
      REG_ENTER:     p_enter = int'($signed(val[16:0]));
      REG_LEAVE:     p_leave = int'($signed(val[16:0]));
      default: ;
    endcase
    clear_predictor();
  endfunction

  // push into a sliding window, return floor mean
  function automatic int unsigned win_push(int id, int unsigned v);
    int unsigned dep;
    dep = WIN_DEPTH[id];
    if (win_fill[id] < dep) win_fill[id]++;
    else win_sum[id] -= win_mem[id][win_pos[id]];
    win_mem[id][win_pos[id]] = v;
    win_sum[id] += v;
    win_pos[id] = (win_pos[id] + 1 == dep) ? 0 : win_pos[id] + 1;
    return int'(win_sum[id] / win_fill[id]);
  endfunction

  function automatic logic [15:0] clamp_thr(int unsigned base, logic wet);
    longint t;
    t = longint'(base) + (wet ? -longint'(p_offset) : longint'(p_offset));
    if (t < 0) return 16'd0;
    if (t > 65535) return 16'hFFFF;
    return t[15:0];
  endfunction

  function automatic verdict_t predict_verdict(stim_t s);
    verdict_t v;
    logic was, nxt, fired;
    int unsigned prim, sec, mean, d, vr, filt, base, span, hi, lo, rng;
    longint rq, dq, w, num;
    was = p_wet;
    nxt = p_wet;
    fired = 1'b0;
    if (p_mode == MODE_DISCRETE) begin
      mean = win_push(WIN_MEAN, s.smp);
      d = (s.smp >= mean) ? s.smp - mean : mean - s.smp;
      vr = win_push(WIN_SQUARE, d * d);
      nxt = vr > p_var_limit;
      prim = (vr > 65535) ? 65535 : vr;
      sec = mean;
      p_wet = nxt;
    end else if (p_mode == MODE_ENVELOPE) begin
      span = p_span;
      if (span < 1) span = 1;
      if (span > RANGE_DEPTH) span = RANGE_DEPTH;
      if (rng_pos >= span) rng_pos = 0;
      rng_mem[rng_pos] = s.smp;
      rng_pos = (rng_pos + 1 == span) ? 0 : rng_pos + 1;
      if (rng_fill < span) rng_fill++;
      hi = rng_mem[0];
      lo = rng_mem[0];
      for (int i = 0; i < rng_fill; i++) begin
        if (rng_mem[i] > hi) hi = rng_mem[i];
        if (rng_mem[i] < lo) lo = rng_mem[i];
      end
      rng = hi - lo;
      rq = longint'(rng) * 256;
      // dry level tracks only while dry
      if (!p_wet) begin
        if (!dry_seeded) begin
          dry_q8 = rq;
          dry_seeded = 1'b1;
        end else begin
          w = (rq > dry_q8) ? p_rise : p_fall;
          if (w < 1) w = 1;
          num = 2 * rq + (w - 1) * dry_q8;
          dry_q8 = (num + (w + 1) / 2) / (w + 1);
        end
      end
      dq = dry_seeded ? dry_q8 : 0;
      if (!p_wet) begin
        if (rq > dq + longint'(p_enter) * 256) nxt = 1'b1;
      end else begin
        if (rq < dq + longint'(p_leave) * 256) nxt = 1'b0;
      end
      prim = hi;
      sec = lo;
      p_wet = nxt;
    end else begin
      filt = win_push(WIN_SHORT, s.smp);
      base = win_push(WIN_SLOW, filt);
      prim = filt;
      sec = base;
      // watchdog on long wet stretches
      if (p_wet) begin
        if (p_wet_since == 0) p_wet_since = s.stamp;
        if (32'(s.stamp - p_wet_since) >= WET_TIMEOUT_MS) begin
          p_wet = 1'b0;
          nxt = 1'b0;
          p_wet_since = '0;
          fired = 1'b1;
        end
      end else begin
        p_wet_since = '0;
      end
      if (!fired) begin
        if (!p_wet)
          nxt = (p_offset >= 0) ? (filt > clamp_thr(base, 1'b0)) : (filt < clamp_thr(base, 1'b0));
        else
          nxt = (p_offset >= 0) ? !(filt < clamp_thr(base, 1'b1)) : !(filt > clamp_thr(base, 1'b1));
        if (nxt != p_wet) begin
          p_wet = nxt;
          p_wet_since = nxt ? s.stamp : 32'd0;
        end
      end
    end
    v.wet = p_wet;
    v.changed = (p_wet != was);
    v.fired = fired;
    v.prim = prim[15:0];
    v.sec = sec[15:0];
    v.thr = clamp_thr(sec, p_wet);
    return v;
  endfunction

  // driver: present queued items, predict on acceptance
  always @(posedge clk) begin
    stim_t s;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_verdicts.push_back(predict_verdict('{smp: sample, stamp: now_ms}));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s = pending_items.pop_front();
          sample <= s.smp;
          now_ms <= s.stamp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    verdict_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result item", 0, 0);
        end else begin
          w = expected_verdicts.pop_front();
          if (water_present !== w.wet) report_mismatch("water_present", water_present, w.wet);
          if (state_changed !== w.changed)
            report_mismatch("state_changed", state_changed, w.changed);
          if (watchdog_fired !== w.fired)
            report_mismatch("watchdog_fired", watchdog_fired, w.fired);
          if (shown_primary !== w.prim) report_mismatch("shown_primary", shown_primary, w.prim);
          if (shown_secondary !== w.sec)
            report_mismatch("shown_secondary", shown_secondary, w.sec);
          if (shown_threshold !== w.thr)
            report_mismatch("shown_threshold", shown_threshold, w.thr);
        end
      end
      out_stall <= hold_rx || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void queue_item(int smp, logic [31:0] stamp);
    pending_items.push_back('{smp: smp[15:0], stamp: stamp});
  endfunction

  // level with steps and noise, clock with occasional long jumps and wraps
  function automatic void queue_random_item();
    int r, v;
    r = $urandom_range(99);
    if (r < 6) lvl = $urandom_range(65535);
    else if (r < 22) lvl = lvl + int'($urandom_range(8000)) - 4000;
    if (lvl < 0) lvl = 0;
    if (lvl > 65535) lvl = 65535;
    if (r >= 95) v = $urandom_range(65535);
    else v = lvl + int'($urandom_range(2 * noise_amp)) - noise_amp;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    r = $urandom_range(99);
    if (r < 3) clock_ms = $urandom;
    else if (r < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    else if (r < 14) clock_ms += $urandom_range(20000000, 1000000);
    else clock_ms += $urandom_range(3000, 1);
    queue_item(v, clock_ms);
  endfunction

  function automatic logic [31:0] pick_margin();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd65535;
    if (r < 20) return -32'sd65535;
    return 32'(int'($urandom_range(6000)) - 3000);
  endfunction

  function automatic logic [31:0] pick_window();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd1;
    if (r < 18) return 32'd65535;
    if (r < 24) return 32'd0;
    return $urandom_range(100, 1);
  endfunction

  function automatic logic [31:0] pick_span();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd1;
    if (r < 20) return 32'd128;
    if (r < 25) return 32'd0;
    if (r < 30) return 32'd255;
    return $urandom_range(40, 2);
  endfunction

  function automatic logic [31:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'hFFFF_FFFF;
    return $urandom_range(200000);
  endfunction

  initial begin
    p_mode = MODE_DYNAMIC;
    p_offset = 0;
    p_var_limit = 0;
    p_span = 30;
    p_rise = 50;
    p_fall = 10;
    p_enter = 0;
    p_leave = 0;
    clear_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, field extremes, timestamp zero and wrap
    queue_item(0, 32'd0);
    queue_item(65535, 32'd0);
    queue_item(65535, 32'hFFFF_FFFF);
    queue_item(65535, 32'd17999999);
    queue_item(65535, 32'd18000000);
    queue_item(0, 32'd18000001);
    queue_item(0, 32'h8000_0000);
    drain();
    // dynamic with negative offset: falling signal means wet
    write_reg(REG_OFFSET, -32'sd100);
    queue_item(40000, 32'd5);
    queue_item(0, 32'd6);
    queue_item(0, 32'd7);
    queue_item(40000, 32'd18000007);
    drain();
    // discrete, limit zero then maximum
    write_reg(REG_MODE, MODE_DISCRETE);
    queue_item(0, 32'd1);
    queue_item(65535, 32'd2);
    queue_item(65535, 32'd3);
    drain();
    write_reg(REG_VAR_LIMIT, 32'hFFFF_FFFF);
    queue_item(0, 32'd4);
    queue_item(65535, 32'd5);
    drain();
    // envelope: single-sample window, then widest window with a negative enter margin and a positive leave margin
    write_reg(REG_MODE, MODE_ENVELOPE);
    write_reg(REG_SPAN, 32'd1);
    queue_item(100, 32'd1);
    queue_item(65535, 32'd2);
    drain();
    write_reg(REG_SPAN, 32'd128);
    write_reg(REG_ENTER, -32'sd65535);
    write_reg(REG_LEAVE, 32'd65535);
    queue_item(0, 32'd1);
    queue_item(65535, 32'd2);
    queue_item(10, 32'd3);
    drain();
    // mode code three behaves as dynamic
    write_reg(REG_MODE, 2'd3);
    queue_item(1234, 32'd9);
    queue_item(60000, 32'd10);
    drain();

    // random phases under three idling regimes
    for (int ph = 0; ph < 24; ph++) begin
      if (ph < 8) begin
        send_idle_pct <= 35;
        recv_idle_pct <= 72;
      end else if (ph < 16) begin
        send_idle_pct <= 72;
        recv_idle_pct <= 35;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      write_reg(REG_OFFSET, pick_margin());
      write_reg(REG_VAR_LIMIT, pick_limit());
      write_reg(REG_SPAN, pick_span());
      write_reg(REG_RISE, pick_window());
      write_reg(REG_FALL, pick_window());
      write_reg(REG_ENTER, pick_margin());
      write_reg(REG_LEAVE, pick_margin());
      write_reg(REG_MODE, (ph % 7 == 6) ? 2'd3 : 2'(ph % 3));
      noise_amp = ($urandom_range(3) == 0) ? 3000 : $urandom_range(200);
      for (int k = 0; k < 35; k++) queue_random_item();
      // receiver holds off long enough for the block to back up its input
      if (ph == 4 || ph == 18) begin
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_rx <= 1'b0;
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
